// ===== rtl/chd_pkg.sv =====
package chd_pkg;

    localparam int WORD_BITS = 32;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BUILD  = 2'd1;
    localparam logic [1:0] OP_WORD   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_MIN_LEN  = 2'd0;
    localparam logic [1:0] CFG_MAX_LEN  = 2'd1;
    localparam logic [1:0] CFG_EXPECTED = 2'd2;

    localparam logic [32:0] LIMIT_TOP = 33'h1_0000_0000;
    localparam logic [34:0] CODE_CAP  = 35'h4_0000_0000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  code_length;
        logic [16:0] length_count;
        logic [31:0] stream_word;
    } t_in_item;

    typedef struct packed {
        logic [15:0] symbol;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  min_code_length;
        logic [5:0]  max_code_length;
        logic [31:0] symbols_expected;
    } t_cfg;

endpackage

// ===== rtl/chd_fifo.sv =====
module chd_fifo #(
    parameter type t_item = logic
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_data,
    output logic  o_empty
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== rtl/chd_front.sv =====
module chd_front import chd_pkg::*; #(
    parameter int MAX_CODE_LEN = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_in,
    output logic     o_full,
    output logic     o_cmd_valid,
    output t_in_item o_cmd,
    input  logic     i_cmd_ready
);

    localparam logic [5:0] MAXL = 6'(MAX_CODE_LEN);

    logic keep;
    logic empty;

    // drop unused operations and loads of lengths outside the table
    always_comb begin
        unique case (i_in.operation)
            OP_LOAD:  keep = (i_in.code_length != 6'd0) && (i_in.code_length <= MAXL);
            OP_BUILD: keep = 1'b1;
            OP_WORD:  keep = 1'b1;
            default:  keep = 1'b0;
        endcase
    end

    chd_fifo #(.t_item(t_in_item)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_data  (i_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_ready),
        .o_data  (o_cmd),
        .o_empty (empty)
    );

    assign o_cmd_valid = !empty;

endmodule

// ===== rtl/chd_back.sv =====
module chd_back import chd_pkg::*; #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_cmd_valid,
    input  t_in_item  i_cmd,
    output logic      o_cmd_ready,
    output logic      o_res_push,
    output t_out_item o_res,
    input  logic      i_res_full
);

    localparam int IW = $clog2(MAX_CODE_LEN);
    localparam logic [5:0] MAXL = 6'(MAX_CODE_LEN);
    localparam logic [31:0] SYM_MASK =
        (SYMBOL_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << SYMBOL_BITS) - 64'd1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]  r_state;
    logic [16:0] r_cnt [MAX_CODE_LEN];
    logic [31:0] r_off [MAX_CODE_LEN];
    logic [32:0] r_lim [MAX_CODE_LEN];
    logic [63:0] r_buf;
    logic [6:0]  r_bits;
    logic [31:0] r_done;
    logic [5:0]  r_l;
    logic [34:0] r_code;
    logic [31:0] r_base;
    logic [MAX_CODE_LEN-1:0] r_stop;
    logic [5:0]  r_n;

    logic [5:0]  lo, hi;
    logic [IW-1:0] bidx;
    logic [34:0] nxt;
    logic [35:0] code2;
    logic [34:0] code_n;
    logic        in_rng;
    logic [32:0] lim;
    logic [31:0] block;
    logic [MAX_CODE_LEN-1:0] stop;
    logic [5:0]  sel_l;
    logic [IW-1:0] sidx;
    logic [31:0] sym32;
    logic        more;

    always_comb begin
        lo = i_cfg.min_code_length;
        if (lo == 6'd0) lo = 6'd1;
        if (lo > MAXL) lo = MAXL;
        hi = i_cfg.max_code_length;
        if (hi > MAXL) hi = MAXL;
        if (hi < lo) hi = lo;
    end

    // one length per cycle of the table build
    always_comb begin
        bidx   = IW'(r_l - 6'd1);
        nxt    = r_code + 35'(r_cnt[bidx]);
        in_rng = (r_l >= lo) && (r_l <= hi);
        if ((r_l == hi) || (nxt >= (35'd1 << r_l)))
            lim = LIMIT_TOP;
        else
            lim = {1'b0, 32'(nxt << (6'd32 - r_l))};
        code2  = {nxt, 1'b0};
        code_n = (code2 > 36'(CODE_CAP)) ? CODE_CAP : code2[34:0];
    end

    assign block = r_buf[63:32];
    // at most 32 symbols for one stream word
    assign more  = (r_bits >= 7'd32) && (r_done < i_cfg.symbols_expected) &&
                   (r_n < 6'd32);

    always_comb begin
        for (int k = 0; k < MAX_CODE_LEN; k++) begin
            stop[k] = (6'(k + 1) >= lo) &&
                      ((6'(k + 1) >= hi) || ({1'b0, block} < r_lim[k]));
        end
    end

    always_comb begin
        sel_l = hi;
        for (int k = MAX_CODE_LEN - 1; k >= 0; k--) begin
            if (r_stop[k]) sel_l = 6'(k + 1);
        end
        sidx  = IW'(sel_l - 6'd1);
        sym32 = 32'(block >> (6'd32 - sel_l)) + r_off[sidx];
    end

    assign o_cmd_ready  = (r_state == ST_IDLE);
    assign o_res_push   = (r_state == ST_EMIT) && !i_res_full;
    assign o_res.symbol = 16'(sym32 & SYM_MASK);
    assign o_res.last   = ((r_done + 32'd1) == i_cfg.symbols_expected);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_buf   <= '0;
            r_bits  <= '0;
            r_done  <= '0;
            r_l     <= 6'd1;
            r_code  <= '0;
            r_base  <= '0;
            r_stop  <= '0;
            r_n     <= '0;
            for (int k = 0; k < MAX_CODE_LEN; k++) begin
                r_off[k] <= '0;
                r_lim[k] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        unique case (i_cmd.operation)
                            OP_BUILD: begin
                                r_buf   <= '0;
                                r_bits  <= '0;
                                r_done  <= '0;
                                r_l     <= 6'd1;
                                r_code  <= '0;
                                r_base  <= '0;
                                r_state <= ST_BUILD;
                            end
                            OP_WORD: begin
                                if (r_done < i_cfg.symbols_expected) begin
                                    r_buf   <= r_buf | ({i_cmd.stream_word, 32'd0} >> r_bits);
                                    r_bits  <= r_bits + 7'd32;
                                    r_n     <= '0;
                                    r_state <= ST_CMP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_BUILD: begin
                    if (in_rng) begin
                        r_off[bidx] <= r_base - r_code[31:0];
                        r_lim[bidx] <= lim;
                        r_base      <= r_base + 32'(r_cnt[bidx]);
                        r_code      <= code_n;
                    end else begin
                        r_off[bidx] <= '0;
                        r_lim[bidx] <= '0;
                    end
                    r_l <= r_l + 6'd1;
                    if (r_l == MAXL) r_state <= ST_IDLE;
                end
                ST_CMP: begin
                    r_stop  <= stop;
                    r_state <= more ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT: begin
                    // hold until the result queue has room
                    if (!i_res_full) begin
                        r_buf   <= r_buf << sel_l;
                        r_bits  <= r_bits - 7'(sel_l);
                        r_done  <= r_done + 32'd1;
                        r_n     <= r_n + 6'd1;
                        r_state <= ST_CMP;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_cmd_valid && (i_cmd.operation == OP_LOAD))
            r_cnt[IW'(i_cmd.code_length - 6'd1)] <= i_cmd.length_count;
    end

endmodule

// ===== rtl/canonical_huffman_decoder_unit.sv =====
// Canonical Huffman decoder, MSB first.
// Input queue: drive i_in and raise i_push while o_full is low. A load word
// sets the code count of one length, a build word derives the offset and
// limit tables and restarts decoding, a stream word adds 32 coded bits.
// Result queue: while o_empty is low, o_out holds the oldest symbol and its
// last flag; raise i_pop to take it.
// Configuration: i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready is
// always high. Write only while the block is idle.
// Steps: a load writes the count of one length in the decode engine, a
// build walks one length per cycle through the count table. A stream word
// is decoded symbol by symbol, each in a compare state (against all limits)
// and then an emit state (select and shift), up to 32 symbols for one word.
// The first symbol reaches the result queue from the emit state.
// Two-entry queues sit on both sides, so input is still queued while results
// wait; when the receiver stops popping, decoding holds on the next symbol.
// Reset clears the queues, offset and limit tables, bit buffer and symbol
// count, and sets the length range to 1..32 with no symbols expected.
module canonical_huffman_decoder_unit import chd_pkg::*; #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in_item    i_in,
    output logic        o_full,
    output logic        o_empty,
    input  logic        i_pop,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      cmd_valid;
    logic      cmd_ready;
    t_in_item  cmd;
    logic      res_push;
    logic      res_full;
    t_out_item res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_code_length  <= 6'd1;
            r_cfg.max_code_length  <= 6'd32;
            r_cfg.symbols_expected <= 32'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MIN_LEN:  r_cfg.min_code_length  <= i_cfg_data[5:0];
                CFG_MAX_LEN:  r_cfg.max_code_length  <= i_cfg_data[5:0];
                CFG_EXPECTED: r_cfg.symbols_expected <= i_cfg_data;
                default: ;
            endcase
        end
    end

    chd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_in        (i_in),
        .o_full      (o_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_ready (cmd_ready)
    );

    chd_back #(.MAX_CODE_LEN(MAX_CODE_LEN), .SYMBOL_BITS(SYMBOL_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    chd_fifo #(.t_item(t_out_item)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (o_out),
        .o_empty (o_empty)
    );

`ifndef NO_ASSERTIONS
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out)))
        else $error("waiting result changed or vanished");
`endif

endmodule
